// File: hw/rtl/ife_pkg.sv
// Shared types, constants and helpers of the interpolated feedback echo.
package ife_pkg;

  localparam int BUFFER_DEPTH = 4096;
  localparam int SAMPLE_WIDTH = 16;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int FILL_W       = ADDR_W + 1;

  localparam int DELAY_W   = 12;
  localparam int FRAC_W    = 16;
  localparam int COEF_W    = 16;
  localparam int COEF_FRAC = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DELAY_MIN = 2;
  localparam int DELAY_MAX = BUFFER_DEPTH - 3;

  localparam int ACC_W   = SAMPLE_WIDTH + 8;
  localparam int MUL_A_W = ACC_W;
  localparam int MUL_B_W = FRAC_W + 2;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SUM_W   = PROD_W + 2;

  localparam logic signed [SUM_W-1:0] SAT_HI =
    SUM_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'sd1 <<< (COEF_FRAC - 1));

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_WHOLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_FRACTION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEFF   = 2'd3;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_READ,
    OP_COEF,
    OP_HMUL,
    OP_HADD,
    OP_XSAT,
    OP_MUL_AX,
    OP_MUL_CS,
    OP_FILT,
    OP_MUL_GS,
    OP_EMIT
  } ife_op_e;

  typedef struct packed {
    ife_op_e    op;
    logic [1:0] idx;
  } ife_cmd_t;

  typedef struct packed {
    logic out_busy;
  } ife_stat_t;

  function automatic sample_t sat_sample(input logic signed [SUM_W-1:0] v);
    sample_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      r = v[SAMPLE_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/ife_if.sv
// Stream interfaces for the input and output sample channels.
interface ife_in_if;
  import ife_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_in;
  modport source(output valid, output sample_in, input ready);
  modport sink(input valid, input sample_in, output ready);
endinterface

interface ife_out_if;
  import ife_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_out;
  modport source(output valid, output sample_out, input ready);
  modport sink(input valid, input sample_out, output ready);
endinterface

// File: hw/rtl/ife_ctrl.sv
// Sequencer that steps the echo datapath through one sample.
module ife_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ife_pkg::ife_stat_t stat_i,
  output ife_pkg::ife_cmd_t  cmd_o
);
  import ife_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_WAIT  = 4'd2;
  localparam logic [3:0] S_COEF  = 4'd3;
  localparam logic [3:0] S_HMUL  = 4'd4;
  localparam logic [3:0] S_HADD  = 4'd5;
  localparam logic [3:0] S_XSAT  = 4'd6;
  localparam logic [3:0] S_MULAX = 4'd7;
  localparam logic [3:0] S_MULCS = 4'd8;
  localparam logic [3:0] S_FILT  = 4'd9;
  localparam logic [3:0] S_MULGS = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;

  logic [3:0] state_q, state_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o.op   = OP_NONE;
    cmd_o.idx  = cnt_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_START;
          cnt_d    = 2'd0;
          state_d  = S_READ;
        end
      end
      S_READ: begin
        // fetch y0 (newest) to y3 (oldest), one tap per cycle
        cmd_o.op = OP_READ;
        cnt_d    = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        state_d = S_COEF;
      end
      S_COEF: begin
        cmd_o.op = OP_COEF;
        cnt_d    = 2'd0;
        state_d  = S_HMUL;
      end
      S_HMUL: begin
        cmd_o.op = OP_HMUL;
        state_d  = S_HADD;
      end
      S_HADD: begin
        cmd_o.op = OP_HADD;
        cnt_d    = cnt_q + 2'd1;
        state_d  = (cnt_q == 2'd2) ? S_XSAT : S_HMUL;
      end
      S_XSAT: begin
        cmd_o.op = OP_XSAT;
        state_d  = S_MULAX;
      end
      S_MULAX: begin
        cmd_o.op = OP_MUL_AX;
        state_d  = S_MULCS;
      end
      S_MULCS: begin
        cmd_o.op = OP_MUL_CS;
        state_d  = S_FILT;
      end
      S_FILT: begin
        cmd_o.op = OP_FILT;
        state_d  = S_MULGS;
      end
      S_MULGS: begin
        cmd_o.op = OP_MUL_GS;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: hw/rtl/ife_datapath.sv
// Delay memory, configuration registers, shared multiplier and output register.
module ife_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ife_pkg::ife_cmd_t                   cmd_i,
  output ife_pkg::ife_stat_t                  stat_o,
  input  logic                                cfg_we_i,
  input  logic [ife_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ife_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  ife_pkg::sample_t                    in_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ife_pkg::sample_t                    out_sample_o
);
  import ife_pkg::*;

  // configuration
  logic [DELAY_W-1:0]       delay_whole_q;
  logic [FRAC_W-1:0]        delay_fraction_q;
  logic signed [COEF_W-1:0] feedback_gain_q;
  logic signed [COEF_W-1:0] filter_coeff_q;

  // sample state
  logic [ADDR_W-1:0] wp_q;
  logic [FILL_W-1:0] fill_q;
  sample_t           s_q;
  sample_t           in_q;
  logic [ADDR_W-1:0] base_q;

  // delay memory and read path
  sample_t           mem [BUFFER_DEPTH];
  sample_t           rd_data_q;
  logic              rd_ok_q;
  logic              rd_pend_q;
  logic [1:0]        rd_idx_q;
  logic [ADDR_W-1:0] rd_addr;
  sample_t           y_q [4];

  // arithmetic
  logic signed [ACC_W-1:0]   k0_q, k1_q, k2_q;
  logic signed [ACC_W-1:0]   e0, e1, e2, e3, d12;
  logic signed [ACC_W-1:0]   acc_q, hk, acc_inc, acc_half;
  logic signed [PROD_W-1:0]  prod_q, prod_d, prod_shr;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [SUM_W-1:0]   sum_q, prod_ext, filt_v, emit_v, xsat_v;
  sample_t                   x_q, out_d;
  logic [COEF_W:0]           coeff_abs, direct_gain;
  logic [DELAY_W-1:0]        delay_clamped;
  logic                      out_valid_q;
  sample_t                   out_q;
  logic                      prod_en;

  // clamp the integer delay into the usable span of the memory
  always_comb begin
    if (delay_whole_q < DELAY_W'(DELAY_MIN)) begin
      delay_clamped = DELAY_W'(DELAY_MIN);
    end else if (32'(delay_whole_q) > DELAY_MAX) begin
      delay_clamped = DELAY_W'(DELAY_MAX);
    end else begin
      delay_clamped = delay_whole_q;
    end
  end

  assign rd_addr = base_q - ADDR_W'(cmd_i.idx);

  // tap polynomial coefficients, doubled
  assign e0  = ACC_W'(y_q[0]);
  assign e1  = ACC_W'(y_q[1]);
  assign e2  = ACC_W'(y_q[2]);
  assign e3  = ACC_W'(y_q[3]);
  assign d12 = e1 - e2;

  always_comb begin
    case (cmd_i.idx)
      2'd0:    hk = k2_q;
      2'd1:    hk = k1_q;
      default: hk = k0_q;
    endcase
  end

  assign coeff_abs   = filter_coeff_q[COEF_W-1] ?
                       (COEF_W+1)'(-(COEF_W+1)'(filter_coeff_q)) :
                       (COEF_W+1)'(filter_coeff_q);
  assign direct_gain = (COEF_W+1)'(1 << COEF_FRAC) - coeff_abs;

  // operand selection for the shared multiplier
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    prod_en = 1'b0;
    case (cmd_i.op)
      OP_HMUL: begin
        mul_a   = acc_q;
        mul_b   = MUL_B_W'(delay_fraction_q);
        prod_en = 1'b1;
      end
      OP_MUL_AX: begin
        mul_a   = MUL_A_W'(x_q);
        mul_b   = MUL_B_W'(direct_gain);
        prod_en = 1'b1;
      end
      OP_MUL_CS: begin
        mul_a   = MUL_A_W'(s_q);
        mul_b   = MUL_B_W'(filter_coeff_q);
        prod_en = 1'b1;
      end
      OP_MUL_GS: begin
        mul_a   = MUL_A_W'(s_q);
        mul_b   = MUL_B_W'(feedback_gain_q);
        prod_en = 1'b1;
      end
      default: begin
        prod_en = 1'b0;
      end
    endcase
  end

  assign prod_d   = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign prod_shr = prod_q >>> FRAC_W;
  assign prod_ext = SUM_W'(prod_q);
  assign acc_inc  = acc_q + ACC_W'(1);
  assign acc_half = acc_inc >>> 1;
  assign xsat_v   = SUM_W'(acc_half);
  assign filt_v   = (sum_q + prod_ext + ROUND_HALF) >>> COEF_FRAC;
  assign emit_v   = ((SUM_W'(in_q) <<< COEF_FRAC) + prod_ext + ROUND_HALF) >>> COEF_FRAC;
  assign out_d    = sat_sample(emit_v);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_whole_q    <= DELAY_W'(DELAY_MIN);
      delay_fraction_q <= '0;
      feedback_gain_q  <= '0;
      filter_coeff_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DELAY_WHOLE:    delay_whole_q    <= cfg_data_i[DELAY_W-1:0];
        REG_DELAY_FRACTION: delay_fraction_q <= cfg_data_i[FRAC_W-1:0];
        REG_FEEDBACK_GAIN:  feedback_gain_q  <= cfg_data_i[COEF_W-1:0];
        REG_FILTER_COEFF:   filter_coeff_q   <= cfg_data_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // control and sample state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      fill_q      <= '0;
      s_q         <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= (cmd_i.op == OP_READ);
      if (cmd_i.op == OP_FILT) begin
        s_q <= sat_sample(filt_v);
      end
      if (cmd_i.op == OP_EMIT) begin
        wp_q        <= wp_q + ADDR_W'(1);
        // entries at or above the fill count were never written and read as zero
        if (fill_q != FILL_W'(BUFFER_DEPTH)) begin
          fill_q <= fill_q + FILL_W'(1);
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_START) begin
      in_q   <= in_sample_i;
      base_q <= wp_q - ADDR_W'(delay_clamped) + ADDR_W'(1);
    end
    if (cmd_i.op == OP_READ) begin
      rd_idx_q <= cmd_i.idx;
      rd_ok_q  <= ({1'b0, rd_addr} < fill_q);
    end
    if (rd_pend_q) begin
      y_q[rd_idx_q] <= rd_ok_q ? rd_data_q : '0;
    end
    if (cmd_i.op == OP_COEF) begin
      k0_q  <= e1 <<< 1;
      k1_q  <= e2 - e0;
      k2_q  <= (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
      acc_q <= (e3 - e0) + (d12 <<< 1) + d12;
    end
    if (cmd_i.op == OP_HADD) begin
      acc_q <= prod_shr[ACC_W-1:0] + hk;
    end
    if (cmd_i.op == OP_XSAT) begin
      x_q <= sat_sample(xsat_v);
    end
    if (prod_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.op == OP_MUL_CS) begin
      sum_q <= prod_ext;
    end
    if (cmd_i.op == OP_EMIT) begin
      out_q <= out_d;
    end
  end

  // delay memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EMIT) begin
      mem[wp_q] <= out_d;
    end
    if (cmd_i.op == OP_READ) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign stat_o.out_busy = out_valid_q & ~out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_sample_o    = out_q;

endmodule

// File: hw/rtl/interpolated_feedback_echo.sv
// Top level of the feedback echo with cubic-interpolated fractional delay.
//
//   Channel   Direction  Beat content           Handshake
//   in_i      sink       sample_in  (Q1.15)     valid / ready
//   out_o     source     sample_out (Q1.15)     valid / ready
//   cfg       write      cfg_idx_i, cfg_data_i  cfg_we_i, no wait
//
// After acceptance, a sample's output beat follows four reads of the single delay
// memory port, then six passes through the one shared multiplier and its adders
// for interpolation, lowpass and gain.
// The next input beat is taken in the cycle after the output register is loaded.
// A stalled output holds the sequencer in its last step; one finished beat waits
// in the output register while the next sample is taken and worked.
// Reset is asynchronous and needs no clearing pass: unwritten memory reads as zero.
module interpolated_feedback_echo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ife_in_if.sink                         in_i,
  ife_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [ife_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ife_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ife_pkg::*;

  ife_cmd_t  cmd;
  ife_stat_t stat;
  logic      in_ready;
  logic      out_valid;
  sample_t   out_sample;

  ife_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ife_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_sample_i  (in_i.sample_in),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_o.ready),
    .out_sample_o (out_sample)
  );

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid;
  assign out_o.sample_out = out_sample;

endmodule

// File: hw/rtl/ife_checker.sv
// Port-level checks on the echo block, bound to its top level.
module ife_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input ife_pkg::sample_t out_sample_i
);

  // one sample at a time: no new beat while the taps are still being fetched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken again straight after a beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |-> ##4 !in_ready_i)
    else $error("input reopened before the sample was worked");

  // a fresh output beat only appears at the end of a sample's sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("output raised while the block was idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_sample_i)))
    else $error("stalled output beat dropped or changed");

endmodule

bind interpolated_feedback_echo ife_checker u_ife_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_sample_i (out_o.sample_out)
);
